// ----- hw/rtl/mws_pkg.sv -----
// shared constants, register indexes and types for the masked 3x3 window sum block
package mws_pkg;

    localparam int MAX_WIDTH_DEFAULT = 512;

    localparam int PIXEL_W   = 8;
    localparam int SUM_W     = 12;
    localparam int LINE_CFG_W = 10;
    localparam int MASK_W    = 9;
    localparam int CFG_DATA_W = 10;
    localparam int WIN_TAPS  = 9;

    localparam logic [LINE_CFG_W-1:0] LINE_WIDTH_RESET  = 10'd450;
    localparam logic [MASK_W-1:0]     WINDOW_MASK_RESET = 9'd341;
    localparam logic [SUM_W-1:0]      SUM_MAX           = 12'd2295;

    typedef enum logic [0:0] {
        REG_LINE_WIDTH  = 1'b0,
        REG_WINDOW_MASK = 1'b1
    } cfg_reg_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        logic full;
        logic last;
    } win_flags_t;

endpackage

// ----- hw/rtl/mws_line_buf.sv -----
// two line stores holding the previous two rows, with a same-edge bypass on the older row
module mws_line_buf #(
    parameter int MAX_WIDTH = mws_pkg::MAX_WIDTH_DEFAULT,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_col,
    input  mws_pkg::pixel_t wr_px,
    input  logic            shift_en,
    input  logic [AW-1:0]   shift_col,
    output mws_pkg::pixel_t top_px,
    output mws_pkg::pixel_t mid_px
);

    mws_pkg::pixel_t mem_a [MAX_WIDTH];
    mws_pkg::pixel_t mem_b [MAX_WIDTH];

    mws_pkg::pixel_t rd_a_reg;
    mws_pkg::pixel_t rd_b_reg;
    mws_pkg::pixel_t fwd_reg;
    logic            hit_reg;

    // newest row: read old value and write the new pixel on the same transfer
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg       <= mem_a[rd_col];
            mem_a[rd_col]  <= wr_px;
        end
    end

    // older row: filled from the newest row one stage later
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            mem_b[shift_col] <= rd_a_reg;
        end
        if (rd_en) begin
            rd_b_reg <= mem_b[rd_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (rd_en) begin
            hit_reg <= shift_en && (shift_col == rd_col);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_reg <= rd_a_reg;
        end
    end

    assign mid_px = rd_a_reg;
    assign top_px = hit_reg ? fwd_reg : rd_b_reg;

endmodule

// ----- hw/rtl/mws_window.sv -----
// 3x3 window shift registers and masked sum of the window
module mws_window (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        shift_en,
    input  mws_pkg::pixel_t             top_px,
    input  mws_pkg::pixel_t             mid_px,
    input  mws_pkg::pixel_t             bot_px,
    input  logic [mws_pkg::MASK_W-1:0]  window_mask,
    output logic [mws_pkg::SUM_W-1:0]   window_sum
);

    mws_pkg::pixel_t win_reg [mws_pkg::WIN_TAPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mws_pkg::WIN_TAPS; i++) begin
                win_reg[i] <= '0;
            end
        end else if (shift_en) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= top_px;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= mid_px;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= bot_px;
        end
    end

    always_comb begin
        logic [mws_pkg::SUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < mws_pkg::WIN_TAPS; i++) begin
            if (window_mask[i]) begin
                acc = acc + mws_pkg::SUM_W'(win_reg[i]);
            end
        end
        window_sum = acc;
    end

endmodule

// ----- hw/rtl/masked_window_sum_3x3.sv -----
// top level: masked 3x3 window sum over a streamed, already padded frame
// Pixels of a padded grey frame come in raster order, one per transfer, and the block
// takes one pixel every clock while the output is not stalled. Each pixel passes three
// register stages: the line-store read, the window shift and the masked sum into the
// output register. One result comes per pixel from the third column on, in each row
// from the third row of a frame on; other pixels only fill the line stores and the
// window. Raising s_tuser on a pixel restarts the row and column count there.
// line_width below 3 acts as 3 and above MAX_WIDTH as MAX_WIDTH. Configuration
// writes are taken at any time but must only be made while no pixel is in flight.
module masked_window_sum_3x3 #(
    parameter int MAX_WIDTH = mws_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel_value
    input  logic                          s_tuser,   // [0] frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [11:0] window_sum, [15:12] zero
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [mws_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (WW0 > mws_pkg::LINE_CFG_W) ? WW0 : mws_pkg::LINE_CFG_W;

    // configuration
    logic [mws_pkg::LINE_CFG_W-1:0] line_width_reg;
    logic [mws_pkg::MASK_W-1:0]     window_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg  <= mws_pkg::LINE_WIDTH_RESET;
            window_mask_reg <= mws_pkg::WINDOW_MASK_RESET;
        end else if (cfg_valid) begin
            unique case (mws_pkg::cfg_reg_t'(cfg_index))
                mws_pkg::REG_LINE_WIDTH:  line_width_reg  <= cfg_data;
                mws_pkg::REG_WINDOW_MASK: window_mask_reg <= cfg_data[mws_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0] width_raw;
    logic [WW-1:0] width_eff;

    assign width_raw = WW'(line_width_reg);

    always_comb begin
        priority if (width_raw < WW'(3)) begin
            width_eff = WW'(3);
        end else if (width_raw > WW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = width_raw;
        end
    end

    // pipeline control
    logic                    s1_valid_reg;
    logic [AW-1:0]           s1_col_reg;
    mws_pkg::pixel_t         s1_px_reg;
    mws_pkg::win_flags_t     s1_flags_reg;
    logic                    w_valid_reg;
    mws_pkg::win_flags_t     w_flags_reg;
    logic                    m_valid_reg;
    logic [mws_pkg::SUM_W-1:0] m_sum_reg;
    logic                    m_last_reg;

    logic out_free;
    logic w_adv;
    logic w_free;
    logic s1_adv;
    logic accept;

    assign out_free = !m_valid_reg || m_tready;
    assign w_adv    = w_valid_reg && (!w_flags_reg.full || out_free);
    assign w_free   = !w_valid_reg || w_adv;
    assign s1_adv   = s1_valid_reg && w_free;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // position tracking
    logic [AW-1:0]       column_count_reg;
    logic [1:0]          row_count_reg;
    logic [AW-1:0]       col_cur;
    logic [1:0]          row_cur;
    logic [WW-1:0]       col_plus;
    mws_pkg::win_flags_t acc_flags;

    assign col_cur         = s_tuser ? '0 : column_count_reg;
    assign row_cur         = s_tuser ? 2'd0 : row_count_reg;
    assign col_plus        = WW'(col_cur) + WW'(1);
    assign acc_flags.last  = (col_plus >= width_eff);
    assign acc_flags.full  = row_cur[1] && (col_cur >= AW'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= 2'd0;
        end else if (accept) begin
            if (acc_flags.last) begin
                column_count_reg <= '0;
                row_count_reg    <= row_cur[1] ? row_cur : row_cur + 2'd1;
            end else begin
                column_count_reg <= col_plus[AW-1:0];
                row_count_reg    <= row_cur;
            end
        end
    end

    // stage 1: line store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg   <= col_cur;
            s1_px_reg    <= s_tdata;
            s1_flags_reg <= acc_flags;
        end
    end

    mws_pkg::pixel_t top_px;
    mws_pkg::pixel_t mid_px;

    mws_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_col    (col_cur),
        .wr_px     (s_tdata),
        .shift_en  (s1_adv),
        .shift_col (s1_col_reg),
        .top_px    (top_px),
        .mid_px    (mid_px)
    );

    // stage 2: window shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            w_valid_reg <= 1'b1;
        end else if (w_adv) begin
            w_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            w_flags_reg <= s1_flags_reg;
        end
    end

    logic [mws_pkg::SUM_W-1:0] window_sum;

    mws_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .shift_en    (s1_adv),
        .top_px      (top_px),
        .mid_px      (mid_px),
        .bot_px      (s1_px_reg),
        .window_mask (window_mask_reg),
        .window_sum  (window_sum)
    );

    // stage 3: output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (w_adv && w_flags_reg.full) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (w_adv && w_flags_reg.full) begin
            m_sum_reg  <= window_sum;
            m_last_reg <= w_flags_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 16'(m_sum_reg);
    assign m_tlast  = m_last_reg;

    // checks
    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_sum_reg <= mws_pkg::SUM_MAX))
        else $error("window sum out of range");

    a_row_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        row_count_reg != 2'd3)
        else $error("row count passed saturation");

    a_full_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_flags_reg.full) |-> (s1_col_reg >= AW'(2)))
        else $error("full window flagged before third column");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (w_valid_reg && w_flags_reg.full && !out_free) |=> w_valid_reg)
        else $error("stalled window dropped");

    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && acc_flags.last) |=> (column_count_reg == '0))
        else $error("column count not cleared at end of row");

endmodule
